// ===== hdl/gsr_pkg.sv =====
// Shared types and constants for the gamepad serial responder.
package gsr_pkg;

  typedef enum logic [1:0] {
    OP_CLOCK  = 2'd0,
    OP_SELECT = 2'd1,
    OP_BUTTON = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  localparam logic [7:0] ADDR_BYTE      = 8'h01;
  localparam logic [7:0] ID_BYTE        = 8'h41;
  localparam logic [7:0] POLL_CMD       = 8'h42;
  localparam logic [7:0] READY_BYTE     = 8'h5A;
  localparam logic [8:0] ACK_DELAY_RST  = 9'd64;

  typedef struct packed {
    logic [15:0] button_bits;
    logic        select_level;
    logic        txd_bit;
    opcode_t     opcode;
  } item_t;

  typedef struct packed {
    logic       pad_active;
    logic       ack_level;
    logic [8:0] ack_delay;
    logic       rxd_bit;
  } result_t;

endpackage

// ===== hdl/gsr_engine.sv =====
// Link protocol engine: exchange state and per-item reply computation.
module gsr_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  gsr_pkg::item_t    item,
  input  logic [8:0]        ack_pulse_delay,
  output gsr_pkg::result_t  result
);

  typedef enum logic [1:0] {
    PH_ADDRESS = 2'd0,
    PH_COMMAND = 2'd1,
    PH_DONE    = 2'd2,
    PH_ABORT   = 2'd3
  } phase_t;

  logic        select_held_r, select_held_nxt;
  logic [15:0] button_store_r, button_store_nxt;
  phase_t      phase_r, phase_nxt;
  logic [2:0]  bit_index_r, bit_index_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  reply_bytes_r [3];
  logic [7:0]  reply_bytes_nxt [3];
  logic [1:0]  reply_index_r, reply_index_nxt;
  logic [1:0]  reply_remaining_r, reply_remaining_nxt;

  always_comb begin
    select_held_nxt     = select_held_r;
    button_store_nxt    = button_store_r;
    phase_nxt           = phase_r;
    bit_index_nxt       = bit_index_r;
    shift_nxt           = shift_r;
    reply_bytes_nxt     = reply_bytes_r;
    reply_index_nxt     = reply_index_r;
    reply_remaining_nxt = reply_remaining_r;
    result.rxd_bit      = 1'b1;
    result.ack_delay    = '0;
    result.pad_active   = 1'b0;

    case (item.opcode)
      gsr_pkg::OP_CLOCK: begin
        if (select_held_r) begin
          if (reply_remaining_r != 2'd0 && reply_index_r != 2'd3) begin
            result.rxd_bit = reply_bytes_r[reply_index_r][bit_index_r];
          end
          shift_nxt[bit_index_r] = item.txd_bit;
          bit_index_nxt = bit_index_r + 3'd1;
          if (bit_index_r == 3'd7) begin
            // byte complete: advance reply queue, then act on phase
            if (reply_remaining_r != 2'd0) begin
              reply_index_nxt     = reply_index_r + 2'd1;
              reply_remaining_nxt = reply_remaining_r - 2'd1;
            end
            unique case (phase_r)
              PH_ADDRESS: begin
                if (shift_nxt != gsr_pkg::ADDR_BYTE) begin
                  phase_nxt = PH_ABORT;
                end else begin
                  reply_bytes_nxt[0]  = gsr_pkg::ID_BYTE;
                  reply_index_nxt     = 2'd0;
                  reply_remaining_nxt = 2'd1;
                  phase_nxt           = PH_COMMAND;
                end
              end
              PH_COMMAND: begin
                reply_bytes_nxt[0] = gsr_pkg::READY_BYTE;
                reply_index_nxt    = 2'd0;
                if (shift_nxt == gsr_pkg::POLL_CMD) begin
                  reply_bytes_nxt[1]  = ~button_store_r[7:0];
                  reply_bytes_nxt[2]  = ~button_store_r[15:8];
                  reply_remaining_nxt = 2'd3;
                  phase_nxt           = PH_DONE;
                  result.pad_active   = 1'b1;
                end else begin
                  reply_bytes_nxt[1]  = '0;
                  reply_bytes_nxt[2]  = '0;
                  reply_remaining_nxt = 2'd0;
                  phase_nxt           = PH_ABORT;
                end
              end
              default: begin
              end
            endcase
            if (reply_remaining_nxt != 2'd0) begin
              result.ack_delay = ack_pulse_delay;
            end
          end
        end
      end
      gsr_pkg::OP_SELECT: begin
        if (!select_held_r && item.select_level) begin
          phase_nxt           = PH_ADDRESS;
          bit_index_nxt       = 3'd0;
          reply_index_nxt     = 2'd0;
          reply_remaining_nxt = 2'd0;
        end
        select_held_nxt = item.select_level;
      end
      gsr_pkg::OP_BUTTON: begin
        button_store_nxt = item.button_bits;
      end
      default: begin
      end
    endcase

    // DSR level reflects state after this item
    result.ack_level = select_held_nxt && (bit_index_nxt == 3'd0) &&
                       (reply_remaining_nxt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      select_held_r     <= 1'b0;
      button_store_r    <= '0;
      phase_r           <= PH_ADDRESS;
      bit_index_r       <= '0;
      shift_r           <= '0;
      reply_bytes_r     <= '{default: '0};
      reply_index_r     <= '0;
      reply_remaining_r <= '0;
    end else if (accept) begin
      select_held_r     <= select_held_nxt;
      button_store_r    <= button_store_nxt;
      phase_r           <= phase_nxt;
      bit_index_r       <= bit_index_nxt;
      shift_r           <= shift_nxt;
      reply_bytes_r     <= reply_bytes_nxt;
      reply_index_r     <= reply_index_nxt;
      reply_remaining_r <= reply_remaining_nxt;
    end
  end

endmodule

// ===== hdl/gamepad_serial_responder.sv =====
// Top level of the gamepad serial responder: stream ports, config and result register.
//
//  Channel | Direction | Handshake          | Payload
//  in_     | slave     | in_tvalid/tready   | tuser opcode, tdata txd/select/buttons
//  out_    | master    | out_tvalid/tready  | tdata rxd/ack_delay/ack_level/pad_active
//  cfg_    | write     | cfg_we             | cfg_wdata ack_pulse_delay
//
// One item per cycle unless out_tready stalls; the accepting edge loads its result.
// The result register is the only stage: in_tready is high when it is empty
// or being drained in the same cycle.
// Reset is synchronous; it clears the exchange state and buttons and returns
// the ack delay to its default.
// A stalled out_tready holds the result and blocks new items.
module gamepad_serial_responder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  input  logic [23:0] in_tdata,   // [0] txd_bit, [1] select_level, [17:2] button_bits, pad 0
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] rxd_bit, [9:1] ack_delay, [10] ack_level,
                                  // [11] pad_active, pad 0
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata
);

  logic              accept;
  gsr_pkg::item_t    item;
  gsr_pkg::result_t  result;
  gsr_pkg::result_t  result_r;
  logic              out_valid_r;
  logic [8:0]        ack_pulse_delay_r;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign item.opcode       = gsr_pkg::opcode_t'(in_tuser);
  assign item.txd_bit      = in_tdata[0];
  assign item.select_level = in_tdata[1];
  assign item.button_bits  = in_tdata[17:2];

  gsr_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .item            (item),
    .ack_pulse_delay (ack_pulse_delay_r),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_pulse_delay_r <= gsr_pkg::ACK_DELAY_RST;
    end else if (cfg_we) begin
      ack_pulse_delay_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload: load on accept only
  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, result_r};

endmodule

// ===== hdl/gsr_checker.sv =====
// Port-level checks for the gamepad serial responder, bound to the top level.
module gsr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a stalled result beat holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted item produced no result");

  a_delay_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9:1] != 9'd0 |-> out_tdata[10])
    else $error("ack delay without ack level");

  a_poll_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |-> out_tdata[10] && out_tdata[15:12] == 4'd0)
    else $error("poll accepted without pending reply bytes");

endmodule

bind gamepad_serial_responder gsr_checker u_gsr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
